// ===== rtl/abr_pkg.sv =====
// shared constants and types of the alternating-bit receiver
package abr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 20;

    // ack codes on the result channel
    localparam logic signed [1:0] ACK_CORRUPT = 2'sb11;
    localparam logic signed [1:0] ACK_NONE    = 2'sb00;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // packet verdict handed from the front end to the delivery sequencer
    typedef struct packed {
        logic              valid;
        logic              deliver;
        logic signed [1:0] ack;
    } abr_verdict_t;

endpackage

// ===== rtl/abr_if.sv =====
// valid/ready channel interfaces for packet bytes and results

interface abr_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         payload_byte;
    logic               end_of_packet;
    logic               seq_bit;
    logic signed [15:0] ack_field;
    logic signed [31:0] sent_checksum;

    modport source (output valid, payload_byte, end_of_packet, seq_bit, ack_field,
                    sent_checksum, input ready);
    modport sink   (input valid, payload_byte, end_of_packet, seq_bit, ack_field,
                    sent_checksum, output ready);
endinterface

interface abr_out_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [7:0]        data_byte;
    logic signed [1:0] ack_number;
    logic              run_end;

    modport source (output valid, kind, data_byte, ack_number, run_end, input ready);
    modport sink   (input valid, kind, data_byte, ack_number, run_end, output ready);
endinterface

// ===== rtl/abr_ram.sv =====
// generic single-write, single-read ram with registered read data
module abr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/abr_drain.sv =====
// delivery sequencer: reads stored bytes back and drives the result register
module abr_drain
    import abr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1,
    localparam int CW = $clog2(PAYLOAD_BYTES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  abr_verdict_t    verdict,
    input  logic [CW-1:0]   count,
    output logic            idle,
    output logic            re,
    output logic [AW-1:0]   raddr,
    input  logic [7:0]      rdata,
    abr_out_if.source       res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DATA,
        S_ACK
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     cnt_reg;
    logic signed [1:0] ack_reg;
    logic              valid_reg;
    logic              kind_reg;
    logic [7:0]        data_reg;
    logic signed [1:0] ackn_reg;
    logic              end_reg;
    logic              out_free;
    logic              load_out;
    logic [CW-1:0]     idx_next;

    assign out_free = !valid_reg || res.ready;
    // result register takes a new byte or the ack this cycle
    assign load_out = out_free && (state_reg == S_DATA || state_reg == S_ACK);
    assign idx_next = idx_reg + CW'(1);
    assign idle     = (state_reg == S_IDLE);
    assign re       = (state_reg == S_READ);
    assign raddr    = idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            ack_reg   <= ACK_NONE;
            valid_reg <= 1'b0;
            kind_reg  <= KIND_DATA;
            data_reg  <= '0;
            ackn_reg  <= ACK_NONE;
            end_reg   <= 1'b0;
        end
        else
        begin
            if (valid_reg && res.ready && !load_out)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (verdict.valid)
                    begin
                        idx_reg <= '0;
                        cnt_reg <= count;
                        ack_reg <= verdict.ack;
                        if (verdict.deliver && count != '0)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_ACK;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    // read data holds until the next read, so a stall just waits
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_DATA;
                        data_reg  <= rdata;
                        ackn_reg  <= ACK_NONE;
                        end_reg   <= 1'b0;
                        idx_reg   <= idx_next;
                        state_reg <= (idx_next == cnt_reg) ? S_ACK : S_READ;
                    end
                end
                S_ACK:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ACK;
                        data_reg  <= '0;
                        ackn_reg  <= ack_reg;
                        end_reg   <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid      = valid_reg;
    assign res.kind       = kind_reg;
    assign res.data_byte  = data_reg;
    assign res.ack_number = ackn_reg;
    assign res.run_end    = end_reg;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_DATA) |-> (idx_reg < cnt_reg))
        else $error("read index beyond stored byte count");

    a_verdict_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (state_reg == S_IDLE))
        else $error("verdict arrived while a run is in progress");

    a_ack_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACK && out_free) |=> (valid_reg && end_reg && kind_reg == KIND_ACK))
        else $error("run did not close with an ack");
`endif

endmodule

// ===== rtl/alternating_bit_receiver.sv =====
// Alternating-bit link receiver. Takes one payload byte per transfer on pkt; a byte
// that is not the end of a packet produces no result. The final byte is judged in
// its own cycle (checksum over seq_bit, ack_field and the stored bytes), then the
// delivery sequencer runs: each delivered byte takes a registered read of the payload
// ram, then a load into the result register, and the ack follows; pkt is held off
// until the sequencer is idle again, for a corrupt or duplicate packet too. Results
// stall cleanly on res.ready.
module alternating_bit_receiver
    import abr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    abr_in_if.sink     pkt,
    abr_out_if.source  res
);

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CW = $clog2(PAYLOAD_BYTES + 1);

    logic          exp_reg;
    logic          prev_valid_reg;
    logic          prev_bit_reg;
    logic [31:0]   sum_reg;
    logic [CW-1:0] count_reg;
    logic          zero_reg;

    logic          accept;
    logic          take;
    logic          store;
    logic [31:0]   sum_next;
    logic [CW-1:0] count_next;
    logic [31:0]   total;
    logic          corrupt;
    logic          dup;
    logic          drain_idle;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    abr_verdict_t  verdict;

    assign pkt.ready = drain_idle;
    assign accept    = pkt.valid && pkt.ready;
    assign take      = !zero_reg && (count_reg < CW'(PAYLOAD_BYTES));
    assign store     = accept && take && (pkt.payload_byte != 8'd0);

    assign sum_next   = sum_reg + (store ? {24'd0, pkt.payload_byte} : 32'd0);
    assign count_next = count_reg + (store ? CW'(1) : CW'(0));

    assign total   = {31'd0, pkt.seq_bit} + {{16{pkt.ack_field[15]}}, pkt.ack_field}
                   + sum_next;
    assign corrupt = (total != pkt.sent_checksum);
    // duplicate only once a packet has been delivered
    assign dup     = prev_valid_reg && (prev_bit_reg == pkt.seq_bit)
                   && (pkt.seq_bit != exp_reg);

    always_comb
    begin
        verdict.valid   = accept && pkt.end_of_packet;
        verdict.deliver = !corrupt && !dup;
        if (corrupt)
        begin
            verdict.ack = ACK_CORRUPT;
        end
        else if (dup)
        begin
            verdict.ack = {1'b0, ~exp_reg};
        end
        else
        begin
            verdict.ack = {1'b0, exp_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg        <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_bit_reg   <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            zero_reg       <= 1'b0;
        end
        else if (accept)
        begin
            if (pkt.end_of_packet)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                zero_reg  <= 1'b0;
                if (verdict.deliver)
                begin
                    prev_valid_reg <= 1'b1;
                    prev_bit_reg   <= pkt.seq_bit;
                    exp_reg        <= ~exp_reg;
                end
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                if (take && pkt.payload_byte == 8'd0)
                begin
                    zero_reg <= 1'b1;
                end
            end
        end
    end

    abr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata (pkt.payload_byte),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    abr_drain #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_drain (
        .clk     (clk),
        .rst_n   (rst_n),
        .verdict (verdict),
        .count   (count_next),
        .idle    (drain_idle),
        .re      (re),
        .raddr   (raddr),
        .rdata   (rdata),
        .res     (res)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PAYLOAD_BYTES))
        else $error("stored byte count exceeds payload size");

    a_bit_steady_midpacket: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !pkt.end_of_packet) |=> $stable(exp_reg))
        else $error("expected bit changed inside a packet");

    a_no_store_after_zero: assert property (@(posedge clk) disable iff (!rst_n)
        zero_reg |-> !store)
        else $error("byte stored after the terminating zero");
`endif

endmodule

// ===== dv/alternating_bit_receiver_tb.sv =====
// self-checking testbench for the alternating-bit link receiver
module alternating_bit_receiver_tb;
    import abr_pkg::*;

    localparam int PB          = PAYLOAD_BYTES_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 60;
    localparam int SETTLE      = 2 * PB + 20;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               end_of_packet;
        logic               seq_bit;
        logic signed [15:0] ack_field;
        logic signed [31:0] sent_checksum;
    } link_byte_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic signed [1:0] ack_number;
        logic              run_end;
    } rx_out_t;

    logic clk;
    logic rst_n;

    abr_in_if  pkt_if ();
    abr_out_if res_if ();

    alternating_bit_receiver u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if),
        .res   (res_if)
    );

    // stimulus and scoreboard storage
    link_byte_t  link_bytes_q[$];
    rx_out_t     rx_out_q[$];
    logic [7:0]  pkt_body[$];

    // receiver state as the block should hold it
    logic        rx_expect_bit;
    logic [1:0]  rx_last_seq;
    logic [31:0] rx_sum;
    int          rx_count;
    logic        rx_zero_seen;
    logic [7:0]  rx_store[PB];

    int  n_queued;
    int  n_accepted;
    int  fail_count;
    int  cycle_count;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_off;
    bit  squeeze_start;
    bit  pkt_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // what the receiver does with one accepted byte
    task automatic receive_byte(input link_byte_t lb);
        logic [31:0] check;
        rx_out_t     r;
        if (!rx_zero_seen && rx_count < PB)
        begin
            if (lb.payload_byte == 8'd0)
                rx_zero_seen = 1'b1;
            else
            begin
                rx_store[rx_count] = lb.payload_byte;
                rx_sum   = rx_sum + {24'd0, lb.payload_byte};
                rx_count = rx_count + 1;
            end
        end
        if (lb.end_of_packet)
        begin
            check = {31'd0, lb.seq_bit} + {{16{lb.ack_field[15]}}, lb.ack_field} + rx_sum;
            r.kind      = KIND_ACK;
            r.data_byte = 8'd0;
            r.run_end   = 1'b1;
            if (check != lb.sent_checksum)
            begin
                r.ack_number = ACK_CORRUPT;
                rx_out_q.push_back(r);
            end
            else if (rx_last_seq == {1'b0, lb.seq_bit} && lb.seq_bit != rx_expect_bit)
            begin
                // duplicate: re-ack the previous packet
                r.ack_number = $signed({1'b0, ~rx_expect_bit});
                rx_out_q.push_back(r);
            end
            else
            begin
                for (int i = 0; i < rx_count; i++)
                    rx_out_q.push_back('{KIND_DATA, rx_store[i], ACK_NONE, 1'b0});
                rx_last_seq  = {1'b0, lb.seq_bit};
                r.ack_number = $signed({1'b0, rx_expect_bit});
                rx_out_q.push_back(r);
                rx_expect_bit = ~rx_expect_bit;
            end
            rx_sum       = 32'd0;
            rx_count     = 0;
            rx_zero_seen = 1'b0;
        end
    endtask

    // turns pkt_body into link bytes; the last one carries the header
    task automatic send_packet(input logic seq_b, input logic signed [15:0] ack_v,
                               input bit good, input logic [31:0] bad_chk);
        logic [31:0] chk;
        int          cnt;
        bit          z;
        link_byte_t  lb;
        chk = {31'd0, seq_b} + {{16{ack_v[15]}}, ack_v};
        cnt = 0;
        z   = 0;
        foreach (pkt_body[i])
        begin
            if (!z && cnt < PB)
            begin
                if (pkt_body[i] == 8'd0)
                    z = 1;
                else
                begin
                    chk = chk + {24'd0, pkt_body[i]};
                    cnt++;
                end
            end
        end
        if (!good)
            chk = (bad_chk == chk) ? (bad_chk ^ 32'd1) : bad_chk;
        foreach (pkt_body[i])
        begin
            lb.payload_byte = pkt_body[i];
            if (i == pkt_body.size() - 1)
            begin
                lb.end_of_packet = 1'b1;
                lb.seq_bit       = seq_b;
                lb.ack_field     = ack_v;
                lb.sent_checksum = chk;
            end
            else
            begin
                // header fields of inner bytes are don't-care
                lb.end_of_packet = 1'b0;
                lb.seq_bit       = 1'($urandom_range(0, 1));
                lb.ack_field     = 16'($urandom);
                lb.sent_checksum = $urandom;
            end
            link_bytes_q.push_back(lb);
            n_queued++;
        end
        pkt_body.delete();
    endtask

    task automatic random_packet();
        int k;
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            // noise: zeros anywhere, checksum a coin toss
            k = $urandom_range(1, 24);
            repeat (k) pkt_body.push_back(8'($urandom_range(0, 255)));
            send_packet(1'($urandom_range(0, 1)), 16'($urandom),
                        bit'($urandom_range(0, 1)), $urandom);
        end
        else
        begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6);
            repeat (k) pkt_body.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 99) < 40 || k == 0)
            begin
                pkt_body.push_back(8'd0);
                repeat ($urandom_range(0, 3)) pkt_body.push_back(8'($urandom_range(0, 255)));
            end
            send_packet(1'($urandom_range(0, 1)), 16'($urandom),
                        $urandom_range(0, 99) < 80, $urandom);
        end
    endtask

    task automatic drain();
        while (n_accepted != n_queued || rx_out_q.size() != 0)
            @(posedge clk);
    endtask

    // sender: new item at the falling edge once the last one was transferred
    always @(negedge clk)
    begin
        if (!rst_n)
            pkt_if.valid <= 1'b0;
        else if (!pkt_if.valid || pkt_sent)
        begin
            if (link_bytes_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                link_byte_t lb;
                lb = link_bytes_q.pop_front();
                pkt_if.valid         <= 1'b1;
                pkt_if.payload_byte  <= lb.payload_byte;
                pkt_if.end_of_packet <= lb.end_of_packet;
                pkt_if.seq_bit       <= lb.seq_bit;
                pkt_if.ack_field     <= lb.ack_field;
                pkt_if.sent_checksum <= lb.sent_checksum;
            end
            else
                pkt_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        res_if.ready <= rst_n && !hold_off && ($urandom_range(0, 99) >= rx_stall_pct);

    // long receiver hold-off so results back up and pkt stalls
    initial
    begin
        hold_off = 1'b0;
        wait (squeeze_start);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // monitor: transfers on both channels at the rising edge
    always @(posedge clk)
    begin
        pkt_sent <= pkt_if.valid && pkt_if.ready;
        if (rst_n && pkt_if.valid && pkt_if.ready)
        begin
            receive_byte('{pkt_if.payload_byte, pkt_if.end_of_packet, pkt_if.seq_bit,
                           pkt_if.ack_field, pkt_if.sent_checksum});
            n_accepted++;
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            rx_out_t got;
            rx_out_t want;
            got = '{res_if.kind, res_if.data_byte, res_if.ack_number, res_if.run_end};
            if (rx_out_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind=%0d data=%02h ack=%0d end=%0d",
                             got.kind, got.data_byte, got.ack_number, got.run_end);
            end
            else
            begin
                want = rx_out_q.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.ack_number !== want.ack_number || got.run_end !== want.run_end)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected kind=%0d data=%02h ack=%0d end=%0d, got kind=%0d data=%02h ack=%0d end=%0d",
                                 want.kind, want.data_byte, want.ack_number, want.run_end,
                                 got.kind, got.data_byte, got.ack_number, got.run_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        pkt_if.valid         = 1'b0;
        pkt_if.payload_byte  = 8'd0;
        pkt_if.end_of_packet = 1'b0;
        pkt_if.seq_bit       = 1'b0;
        pkt_if.ack_field     = 16'sd0;
        pkt_if.sent_checksum = 32'sd0;
        res_if.ready         = 1'b0;
        pkt_sent             = 1'b0;
        squeeze_start        = 1'b0;
        tx_idle_pct          = 0;
        rx_stall_pct         = 0;
        n_queued             = 0;
        n_accepted           = 0;
        fail_count           = 0;
        cycle_count          = 0;
        rx_expect_bit        = 1'b0;
        rx_last_seq          = 2'd2;
        rx_sum               = 32'd0;
        rx_count             = 0;
        rx_zero_seen         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first packet after reset: empty payload, no previous sequence yet
        pkt_body.push_back(8'h00);
        send_packet(1'b1, 16'sh0000, 1, 32'd0);
        // same seq as last but equal to the expected bit: accepted
        pkt_body.push_back(8'hFF);
        send_packet(1'b1, 16'sh7FFF, 1, 32'd0);
        // duplicate
        pkt_body.push_back(8'h80);
        send_packet(1'b1, -16'sd32768, 1, 32'd0);
        // corrupt, with bytes after the terminator
        pkt_body = '{8'h03, 8'h00, 8'h09};
        send_packet(1'b0, -16'sd1, 0, 32'h8000_0000);
        // full payload plus one byte past the limit
        repeat (PB) pkt_body.push_back(8'($urandom_range(1, 255)));
        pkt_body.push_back(8'hFF);
        send_packet(1'b0, 16'($urandom), 1, 32'd0);
        pkt_body = '{8'h05, 8'h00};
        send_packet(1'b1, 16'sh1234, 1, 32'd0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                3: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
                default:
                begin
                    tx_idle_pct   = 0;
                    rx_stall_pct  = 0;
                    squeeze_start = 1'b1;
                end
            endcase
            begin
                int goal;
                goal = n_queued + PHASE_ITEMS;
                while (n_queued < goal)
                    random_packet();
            end
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        if (rx_out_q.size() != 0)
        begin
            $display("%0d expected results never arrived", rx_out_q.size());
            fail_count += rx_out_q.size();
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/abr_pkg.sv
rtl/abr_if.sv
rtl/abr_ram.sv
rtl/abr_drain.sv
rtl/alternating_bit_receiver.sv
dv/alternating_bit_receiver_tb.sv
